[rtl/rxcc_pkg.sv]
`timescale 1ns / 1ps

package rxcc_pkg;

  // Fixed field widths of the byte stream and the rolling sum.
  localparam int BYTE_W  = 8;
  localparam int SUM_W   = 32;
  localparam int POS_W   = 32;
  localparam int SPLIT_W = 5;

  // Split threshold after reset.
  localparam logic [SPLIT_W-1:0] SPLIT_BITS_RESET = 5'd13;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [POS_W-1:0]  pos_t;

  // Rotate left by one, then mix in the leaving and entering bytes.
  function automatic sum_t rot_xor(input sum_t prev, input byte_t leaving,
                                   input byte_t entering);
    sum_t rot;
    rot = {prev[SUM_W-2:0], prev[SUM_W-1]};
    return rot ^ {{(SUM_W-BYTE_W){1'b0}}, leaving} ^ {{(SUM_W-BYTE_W){1'b0}}, entering};
  endfunction

endpackage

[rtl/rolling_xor_content_chunker_top.sv]
`timescale 1ns / 1ps

// A result is registered and presented in the cycle after its input transfer.
// Throughput: one byte per cycle unless the output stalls; the window ring is a
// memory with one write and one registered read per cycle, its read address set up one item ahead.
// Reset (synchronous, active high) clears the sum, ring index, byte count and output
// valid and loads split_bits with 13; ring contents are masked until rewritten.
module rolling_xor_content_chunker_top #(
  parameter int WINDOW_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rxcc_pkg::SPLIT_W-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rxcc_pkg::BYTE_W-1:0]   data_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rxcc_pkg::BYTE_W-1:0]   byte_out,
  output logic                          chunk_start,
  output logic [rxcc_pkg::POS_W-1:0]    stream_position
);

  localparam int IDX_W = $clog2(WINDOW_BYTES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_BYTES - 1);

  logic [rxcc_pkg::SPLIT_W-1:0] split_bits;
  logic [IDX_W-1:0]             ring_index;
  logic [IDX_W-1:0]             ring_index_next;
  logic                         wrapped;
  logic                         wrapped_next;
  rxcc_pkg::sum_t               rolling_sum;
  rxcc_pkg::sum_t               sum_upd;
  rxcc_pkg::sum_t               split_mask;
  rxcc_pkg::pos_t               byte_count;
  rxcc_pkg::pos_t               count_upd;
  rxcc_pkg::byte_t              ring_mem [WINDOW_BYTES];
  rxcc_pkg::byte_t              ring_rd;
  rxcc_pkg::byte_t              leaving;
  logic                         split;
  logic                         in_fire;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      split_bits <= rxcc_pkg::SPLIT_BITS_RESET;
    end else if (cfg_valid) begin
      split_bits <= cfg_data;
    end
  end

  // The output register frees up in the same cycle its result is taken.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // A slot not yet rewritten since the last split reads as zero; until the index
  // wraps, every slot it reaches is such a slot.
  assign leaving    = wrapped ? ring_rd : '0;
  assign sum_upd    = rxcc_pkg::rot_xor(rolling_sum, leaving, data_byte);
  assign split_mask = (rxcc_pkg::sum_t'(1) << split_bits) - rxcc_pkg::sum_t'(1);
  assign split      = (sum_upd & split_mask) == '0;
  assign count_upd  = byte_count + rxcc_pkg::pos_t'(1);

  // Next ring index and wrap flag.
  always_comb begin
    ring_index_next = ring_index;
    wrapped_next    = wrapped;
    if (in_fire) begin
      if (split) begin
        ring_index_next = '0;
        wrapped_next    = 1'b0;
      end else if (ring_index == IDX_LAST) begin
        ring_index_next = '0;
        wrapped_next    = 1'b1;
      end else begin
        ring_index_next = ring_index + IDX_W'(1);
      end
    end
  end

  // Chunker state.
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_index  <= '0;
      wrapped     <= 1'b0;
      rolling_sum <= '0;
      byte_count  <= '0;
    end else begin
      ring_index <= ring_index_next;
      wrapped    <= wrapped_next;
      if (in_fire) begin
        rolling_sum <= split ? '0 : sum_upd;
        byte_count  <= count_upd;
      end
    end
  end

  // Window ring memory: write the new byte, and read ahead at the next index.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ring_mem[ring_index] <= data_byte;
    end
    ring_rd <= ring_mem[ring_index_next];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_out        <= data_byte;
      chunk_start     <= split;
      stream_position <= count_upd;
    end
  end

  // A split leaves the sum, index and wrap flag cleared.
  assert property (@(posedge clk) disable iff (rst)
    in_fire && split |=> rolling_sum == '0 && ring_index == '0 && !wrapped)
    else $error("split did not clear the chunker state");

  // Every input transfer shows its byte and position in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid && byte_out == $past(data_byte)
      && stream_position == byte_count)
    else $error("result does not match the accepted byte");

  // The wrap flag is only set by an index wrap without a split.
  assert property (@(posedge clk) disable iff (rst)
    $rose(wrapped) |-> $past(in_fire) && $past(ring_index) == IDX_LAST && !$past(split))
    else $error("wrap flag set without an index wrap");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int WINDOW = 64;

  typedef logic [rxcc_pkg::SPLIT_W-1:0] split_t;

  // Shadow of the chunker: window ring, slot pointer, rolling sum and byte count.
  typedef struct {
    rxcc_pkg::byte_t ring [WINDOW];
    int unsigned     slot;
    rxcc_pkg::sum_t  sum;
    rxcc_pkg::pos_t  count;
  } chunker_state_t;

  // One predicted output beat.
  typedef struct {
    rxcc_pkg::byte_t data;
    logic            start;
    rxcc_pkg::pos_t  pos;
  } chunk_beat_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  split_t          cfg_data = '0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  rxcc_pkg::byte_t data_byte = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  rxcc_pkg::byte_t byte_out;
  logic            chunk_start;
  rxcc_pkg::pos_t  stream_position;

  rolling_xor_content_chunker_top #(
    .WINDOW_BYTES(WINDOW)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .byte_out       (byte_out),
    .chunk_start    (chunk_start),
    .stream_position(stream_position)
  );

  // Predictor state, driven by accepted input transfers.
  chunker_state_t live_state;
  split_t         live_split;
  // Planning state, advanced as bytes are queued so splits can be steered.
  chunker_state_t plan_state;
  split_t         plan_split;

  rxcc_pkg::byte_t pending_bytes [$];
  chunk_beat_t     expected_beats [$];

  int          error_count = 0;
  int          bytes_sent = 0;
  int          beats_checked = 0;
  int          starts_seen = 0;
  int          settings_used = 0;
  int          send_gap = 0;
  int          recv_stall = 0;
  logic        idle_off = 1'b0;
  chunk_beat_t beat_tmp;
  chunk_beat_t beat_ref;

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void clear_chunker(inout chunker_state_t st);
    for (int i = 0; i < WINDOW; i++) st.ring[i] = '0;
    st.slot = 0;
    st.sum  = '0;
  endfunction

  function automatic rxcc_pkg::sum_t split_mask(input split_t sb);
    return rxcc_pkg::sum_t'((64'd1 << sb) - 64'd1);
  endfunction

  // Sum after rotation and removal of the leaving byte, before the new byte mixes in.
  function automatic rxcc_pkg::sum_t rotated_less_leaving(input chunker_state_t st);
    rxcc_pkg::sum_t r;
    r = {st.sum[rxcc_pkg::SUM_W-2:0], st.sum[rxcc_pkg::SUM_W-1]};
    return r ^ rxcc_pkg::sum_t'(st.ring[st.slot]);
  endfunction

  // Advance the chunker by one byte; returns 1 when the byte starts a new chunk.
  function automatic logic advance_chunker(inout chunker_state_t st,
                                           input rxcc_pkg::byte_t b,
                                           input split_t sb);
    logic hit;
    st.sum = rotated_less_leaving(st) ^ rxcc_pkg::sum_t'(b);
    st.ring[st.slot] = b;
    st.slot = (st.slot == WINDOW - 1) ? 0 : st.slot + 1;
    st.count = st.count + 1'b1;
    hit = (st.sum & split_mask(sb)) == '0;
    if (hit) clear_chunker(st);
    return hit;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // Queue one byte for the driver and keep the planning copy in step.
  task automatic queue_byte(input rxcc_pkg::byte_t b);
    void'(advance_chunker(plan_state, b, plan_split));
    pending_bytes.push_back(b);
  endtask

  // Pick a byte that forces a split when the low byte alone can clear the mask.
  function automatic rxcc_pkg::byte_t pick_split_byte(input split_t sb, output logic ok);
    rxcc_pkg::sum_t  pre;
    rxcc_pkg::sum_t  m;
    rxcc_pkg::byte_t keep;
    pre  = rotated_less_leaving(plan_state);
    m    = split_mask(sb);
    keep = m[rxcc_pkg::BYTE_W-1:0];
    ok   = ((pre & m) >> rxcc_pkg::BYTE_W) == '0;
    return (pre[rxcc_pkg::BYTE_W-1:0] & keep)
         | (rxcc_pkg::byte_t'($urandom_range(0, 255)) & ~keep);
  endfunction

  // Wait for every queued byte to transfer and every result to arrive, then settle.
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid || expected_beats.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_split(input split_t v);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    live_split = v;
    plan_split = v;
    settings_used++;
  endtask

  // Driver: presents queued bytes, with random bursts of idle cycles.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid) begin
        beat_tmp.data  = data_byte;
        beat_tmp.start = advance_chunker(live_state, data_byte, live_split);
        beat_tmp.pos   = live_state.count;
        expected_beats.push_back(beat_tmp);
        void'(pending_bytes.pop_front());
        bytes_sent++;
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        if (!idle_off && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 13) - 1;
          in_valid <= 1'b0;
        end else begin
          in_valid  <= 1'b1;
          data_byte <= pending_bytes[0];
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each output transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected output, byte", byte_out, 0);
        end else begin
          beat_ref = expected_beats.pop_front();
          beats_checked++;
          if (chunk_start === 1'b1) starts_seen++;
          if (byte_out !== beat_ref.data)
            report_mismatch("byte_out", byte_out, beat_ref.data);
          if (chunk_start !== beat_ref.start)
            report_mismatch("chunk_start", chunk_start, beat_ref.start);
          if (stream_position !== beat_ref.pos)
            report_mismatch("stream_position", stream_position, beat_ref.pos);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("rolling_xor_content_chunker_top verification failed");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    rxcc_pkg::byte_t b;
    logic            ok;
    split_t          sb;
    int              force_rate;
    int              n_phases;

    clear_chunker(live_state);
    live_state.count = '0;
    clear_chunker(plan_state);
    plan_state.count = '0;
    live_split = rxcc_pkg::SPLIT_BITS_RESET;
    plan_split = rxcc_pkg::SPLIT_BITS_RESET;

    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset threshold; a zero first byte splits at once, then 01 02 cancels to zero.
    queue_byte(8'h00); queue_byte(8'h01); queue_byte(8'h02); queue_byte(8'hFF);
    queue_byte(8'h80); queue_byte(8'h7F); queue_byte(8'h55); queue_byte(8'hAA);

    // An empty mask: every byte begins a chunk.
    write_split('0);
    @(negedge clk);
    queue_byte(8'hFF); queue_byte(8'h00); queue_byte(8'h3C);

    // Widest mask.
    write_split(5'd31);
    @(negedge clk);
    queue_byte(8'h00); queue_byte(8'h01); queue_byte(8'h02); queue_byte(8'hFE);
    queue_byte(8'h01);

    // Narrowest nonzero mask.
    write_split(5'd1);
    @(negedge clk);
    queue_byte(8'h01); queue_byte(8'h03); queue_byte(8'h02); queue_byte(8'h80);
    queue_byte(8'h00);

    // Random phases, mostly with small masks so chunks both split and wrap the ring.
    n_phases = 12;
    for (int p = 0; p < n_phases; p++) begin
      case (p)
        0:       sb = 5'd31;
        1:       sb = 5'd13;
        2:       sb = '0;
        3:       sb = 5'd1;
        4:       sb = split_t'($urandom_range(0, 31));
        default: sb = split_t'($urandom_range(2, 10));
      endcase
      write_split(sb);
      @(negedge clk);
      idle_off   = (p >= n_phases - 2) || ($urandom_range(0, 4) == 0);
      force_rate = $urandom_range(8, 40);
      for (int k = 0; k < 120; k++) begin
        b = pick_split_byte(plan_split, ok);
        if (!(ok && $urandom_range(0, 99) < force_rate))
          b = rxcc_pkg::byte_t'($urandom_range(0, 255));
        queue_byte(b);
      end
    end

    // Drain, then keep running so any stray output is exposed.
    wait_drained();
    repeat (10) @(posedge clk);

    $display("Streamed %0d bytes across %0d split settings; %0d results checked.",
             bytes_sent, settings_used + 1, beats_checked);
    $display("Chunk starts observed: %0d; mismatches: %0d.", starts_seen, error_count);
    if (error_count == 0 && expected_beats.size() == 0) begin
      $display("rolling_xor_content_chunker_top verification clean");
    end else begin
      $display("rolling_xor_content_chunker_top verification failed");
    end
    $finish;
  end

endmodule
